>>> hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control types for the bitmap block allocator.
// No dependencies; every other file imports it.
package bba_pkg;

  localparam int MAX_BLOCKS = 32768;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CAP_W      = $clog2(MAX_BLOCKS + 1);
  localparam int BASE_W     = WORD_AW + BIT_W;
  localparam int SUM_W      = ((BASE_W > CAP_W) ? BASE_W : CAP_W) + 1;
  localparam int IDX_W      = 15;
  localparam int CFG_W      = 16;
  localparam int REQ_W      = 2;
  localparam int CAP_DEFAULT = 32768;
  localparam int CAP_RESET  = (CAP_DEFAULT > MAX_BLOCKS) ? MAX_BLOCKS : CAP_DEFAULT;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_MARK    = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_CLEAR  = 2'd1,
    WR_GRANT  = 2'd2,
    WR_UPDATE = 2'd3
  } wr_op_t;

  typedef enum logic {
    RD_SCAN   = 1'b0,
    RD_TARGET = 1'b1
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_NULL  = 2'd0,
    RES_GRANT = 2'd1,
    RES_NONE  = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      load_req;
    logic      scan_adv;
    rd_sel_t   rd_sel;
    wr_op_t    wr_op;
    logic      emit;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_last;
  } dp_status_t;

endpackage

>>> hw/rtl/bba_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the bitmap allocator: clearing pass, word scan, read-modify-write.
// Depends on bba_pkg; drives bba_dpath through dp_cmd_t.
module bba_ctrl
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  dp_status_t       status,
  output logic             busy,
  output dp_cmd_t          cmd
);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SCAN_RD = 6'b000100,
    S_SCAN    = 6'b001000,
    S_FETCH   = 6'b010000,
    S_MODIFY  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.load_req = 1'b0;
    cmd.scan_adv = 1'b0;
    cmd.rd_sel   = RD_SCAN;
    cmd.wr_op    = WR_NONE;
    cmd.emit     = 1'b0;
    cmd.res_kind = RES_NULL;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_op = WR_CLEAR;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          unique case (req_type) inside
            REQ_ALLOC:            state_next = S_SCAN_RD;
            REQ_RELEASE, REQ_MARK: state_next = S_FETCH;
            default: begin
              // unused code: answer at once, map untouched
              cmd.emit     = 1'b1;
              cmd.res_kind = RES_NULL;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd.scan_adv = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_hit) begin
          cmd.wr_op    = WR_GRANT;
          cmd.emit     = 1'b1;
          cmd.res_kind = RES_GRANT;
          state_next   = S_IDLE;
        end else if (status.scan_last) begin
          cmd.emit     = 1'b1;
          cmd.res_kind = RES_NONE;
          state_next   = S_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_FETCH: begin
        cmd.rd_sel = RD_TARGET;
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.rd_sel   = RD_TARGET;
        cmd.wr_op    = WR_UPDATE;
        cmd.emit     = 1'b1;
        cmd.res_kind = RES_NULL;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hw/rtl/bba_dpath.sv
`timescale 1ns / 1ps
// Datapath of the bitmap allocator: map memory, block count, scan pointers,
// lowest-free-bit encoder and result registers. Depends on bba_pkg.
module bba_dpath
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  logic [REQ_W-1:0] req_type,
  input  logic [IDX_W-1:0] block_index,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  output dp_status_t       status,
  output logic             done,
  output logic [IDX_W-1:0] granted_index,
  output logic             none_free
);

  localparam int CMP_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [CAP_W-1:0]     cap;
  logic [IDX_W-1:0]     tgt_index;
  logic                 set_bit;
  logic [WORD_AW-1:0]   rd_word;
  logic [WORD_AW-1:0]   ex_word;
  logic [WORD_AW-1:0]   clr_word;

  logic [WORD_AW-1:0]   rd_addr;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;
  logic [WORD_AW-1:0]   tgt_word;
  logic [WORD_BITS-1:0] tgt_mask;
  logic                 in_range;
  logic [SUM_W-1:0]     base_ext;
  logic [SUM_W-1:0]     cap_ext;
  logic [SUM_W-1:0]     avail;
  logic                 scan_empty;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     hit_bit;

  // configuration: store the count already clamped to capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_W'(CAP_RESET);
    end else if (cfg_valid) begin
      if (CMP_W'(cfg_data) > CMP_W'(MAX_BLOCKS)) begin
        cap <= CAP_W'(MAX_BLOCKS);
      end else begin
        cap <= CAP_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      tgt_index <= block_index;
      set_bit   <= (req_type == REQ_MARK);
    end
  end

  // scan pointers: rd_word is being read, ex_word is being examined
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_word <= '0;
      ex_word <= '0;
    end else if (cmd.load_req) begin
      rd_word <= '0;
      ex_word <= '0;
    end else if (cmd.scan_adv) begin
      rd_word <= rd_word + 1'b1;
      ex_word <= rd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_word <= '0;
    end else if (cmd.wr_op == WR_CLEAR) begin
      clr_word <= clr_word + 1'b1;
    end
  end

  assign status.clear_last = (clr_word == WORD_AW'(MAP_WORDS - 1));

  assign tgt_word = WORD_AW'(tgt_index >> BIT_W);
  assign tgt_mask = WORD_BITS'(1) << tgt_index[BIT_W-1:0];
  assign rd_addr  = (cmd.rd_sel == RD_TARGET) ? tgt_word : rd_word;

  // scan window: bits at or above the count read as used
  assign cap_ext    = SUM_W'(cap);
  assign base_ext   = SUM_W'({ex_word, {BIT_W{1'b0}}});
  assign in_range   = SUM_W'(tgt_index) < cap_ext;
  assign scan_empty = base_ext >= cap_ext;
  assign avail      = cap_ext - base_ext;
  assign status.scan_last = (base_ext + SUM_W'(WORD_BITS)) >= cap_ext;

  always_comb begin
    if (avail >= SUM_W'(WORD_BITS)) begin
      valid_mask = '1;
    end else begin
      valid_mask = ~({WORD_BITS{1'b1}} << avail[BIT_W-1:0]);
    end
  end

  assign free_bits = ~rd_data & valid_mask;

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  assign status.scan_hit = (|free_bits) && !scan_empty;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_word;
    wr_data = rd_data;
    case (cmd.wr_op)
      WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_word;
        wr_data = (clr_word == '0) ? WORD_BITS'(1) : '0;
      end
      WR_GRANT: begin
        wr_en   = 1'b1;
        wr_addr = ex_word;
        wr_data = rd_data | (WORD_BITS'(1) << hit_bit);
      end
      WR_UPDATE: begin
        wr_en   = in_range;
        wr_addr = tgt_word;
        wr_data = set_bit ? (rd_data | tgt_mask) : (rd_data & ~tgt_mask);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      granted_index <= (cmd.res_kind == RES_GRANT) ? IDX_W'({ex_word, hit_bit}) : '0;
      none_free     <= (cmd.res_kind == RES_NONE);
    end
  end

endmodule

>>> hw/rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
//  channel   | signals                              | transfer
//  ----------+--------------------------------------+---------------------------
//  request   | start, busy, req_type, block_index   | start high, busy low
//  result    | done, granted_index, none_free       | done high, one cycle only
//  config    | cfg_valid, cfg_ready, cfg_data       | cfg_valid and cfg_ready
//
// Allocate: a read step, then a scan of W map words, W being the number of words
//   examined (1..512); the scan reads one 64-bit word per cycle from the map RAM.
// Release and mark: read, modify, write back. Unused request code: answered at once.
// After reset the map is swept clean, one word per cycle, block 0 kept reserved;
//   busy stays high for the sweep. Config writes are taken at any time, cfg_ready is
//   always high. A result is never held: done pulses for one cycle, and a new
//   request may be transferred in that same cycle.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [REQ_W-1:0] req_type,
  input  logic [IDX_W-1:0] block_index,
  output logic             done,
  output logic [IDX_W-1:0] granted_index,
  output logic             none_free,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // the count register accepts a write in every cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns the request handshake and drives all datapath commands
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  // map storage, scan datapath and result registers
  bba_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .block_index   (block_index),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .status        (status),
    .done          (done),
    .granted_index (granted_index),
    .none_free     (none_free)
  );

endmodule

>>> hw/rtl/bba_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker
  import bba_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [IDX_W-1:0] granted_index,
  input logic             none_free
);

  // reset starts the clearing sweep, so no request may slip in
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // a transferred request either completes at once or holds the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request transfer lost");

  // a result is only shown once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && none_free) |-> (granted_index == '0))
    else $error("non-zero index with none_free");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .granted_index (granted_index),
  .none_free     (none_free)
);

>>> tb/sv/bba_grant_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the bitmap block allocator: a bit-exact copy of the used map
// and block count, plus the queue of grants still due. Depends on bba_pkg.
package bba_grant_sb_pkg;

  import bba_pkg::*;

  // request code the block must treat as a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic             none_free;
  } grant_t;

  class grant_checker;
    logic [WORD_BITS-1:0] used_words [MAP_WORDS];
    logic [CFG_W-1:0]     block_count;
    grant_t               grants_due [$];
    int unsigned          fail_count;

    function new();
      foreach (used_words[w]) used_words[w] = '0;
      used_words[0][0] = 1'b1;
      block_count = CFG_W'(CAP_RESET);
      fail_count  = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      block_count = value;
    endfunction

    // a count above capacity behaves as full capacity
    function int unsigned tracked();
      return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
    endfunction

    function int pending();
      return grants_due.size();
    endfunction

    // drop writes outside the tracked range
    function void set_bit(int unsigned idx, logic val);
      if (idx >= tracked()) return;
      used_words[idx / WORD_BITS][idx % WORD_BITS] = val;
    endfunction

    // lowest clear bit below the tracked count, first fit
    function bit lowest_free(output int unsigned found);
      int unsigned cap;
      int unsigned idx;
      cap   = tracked();
      found = 0;
      for (int unsigned w = 0; w < MAP_WORDS && w * WORD_BITS < cap; w++) begin
        if (&used_words[w]) continue;
        for (int unsigned b = 0; b < WORD_BITS; b++) begin
          idx = w * WORD_BITS + b;
          if (idx >= cap) return 1'b0;
          if (!used_words[w][b]) begin
            found = idx;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // apply one accepted request and queue the grant it must produce
    function grant_t predict_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx);
      grant_t      g;
      int unsigned hit;
      g = '0;
      case (kind)
        REQ_ALLOC: begin
          if (lowest_free(hit)) begin
            set_bit(hit, 1'b1);
            g.granted_index = hit[IDX_W-1:0];
          end else begin
            g.none_free = 1'b1;
          end
        end
        REQ_RELEASE: set_bit(idx, 1'b0);
        REQ_MARK:    set_bit(idx, 1'b1);
        default: ;
      endcase
      grants_due.push_back(g);
      return g;
    endfunction

    function void check_result(logic [IDX_W-1:0] granted, logic none);
      grant_t want;
      if (grants_due.size() == 0) begin
        $error("unexpected result: granted_index %0d none_free %0b", granted, none);
        fail_count++;
        return;
      end
      want = grants_due.pop_front();
      if (granted !== want.granted_index) begin
        $error("granted_index: expected %0d, actual %0d", want.granted_index, granted);
        fail_count++;
      end
      if (none !== want.none_free) begin
        $error("none_free: expected %0b, actual %0b", want.none_free, none);
        fail_count++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_block_allocator: directed corner requests,
// then randomised phases over several block counts. Depends on bba_pkg and bba_grant_sb_pkg.
module tb_top;

  import bba_pkg::*;
  import bba_grant_sb_pkg::*;

  // Slowest legal run is roughly 950 requests, each a full scan plus the longest gap,
  // plus the sweep after reset; give it several times that.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 93;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] block_index;
  logic             done;
  logic [IDX_W-1:0] granted_index;
  logic             none_free;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  grant_checker     sb = new();
  logic [IDX_W-1:0] granted_pool [$];
  bit               gaps_on = 1'b1;
  int unsigned      cycle_count = 0;

  always #2 clk = ~clk;

  bitmap_block_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .block_index   (block_index),
    .done          (done),
    .granted_index (granted_index),
    .none_free     (none_free),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Results cannot be held off: take every done pulse at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(granted_index, none_free);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Favour blocks known to be granted and in-range indices; keep some wild ones
  // so that every index bit toggles and out-of-range requests occur.
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r;
    int unsigned lim;
    r   = $urandom_range(0, 99);
    lim = sb.tracked();
    if (r < 12 || lim == 0) return IDX_W'($urandom);
    if (r < 50 && granted_pool.size() != 0)
      return granted_pool[$urandom_range(0, granted_pool.size() - 1)];
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  // Hold the request until the block takes it, then note the transfer.
  // Leave start high when the next request follows straight on.
  task automatic issue(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx);
    grant_t      g;
    int unsigned gap;
    start       <= 1'b1;
    req_type    <= kind;
    block_index <= idx;
    do @(posedge clk); while (busy);
    g = sb.predict_request(kind, idx);
    if (kind == REQ_ALLOC && !g.none_free) begin
      granted_pool.push_back(g.granted_index);
      if (granted_pool.size() > 256) void'(granted_pool.pop_front());
    end
    gap = pick_gap();
    if (gap != 0) begin
      start       <= 1'b0;
      req_type    <= REQ_W'($urandom);
      block_index <= IDX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every grant due has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned      r;
    logic [CFG_W-1:0] count;

    rst         <= 1'b1;
    start       <= 1'b0;
    req_type    <= REQ_ALLOC;
    block_index <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset count, block 0 reserved, release of block 0, top index.
    issue(REQ_ALLOC, '0);
    issue(REQ_ALLOC, '1);
    issue(REQ_RELEASE, '0);
    issue(REQ_ALLOC, '0);
    issue(REQ_ALLOC, '0);
    issue(REQ_MARK, IDX_W'(MAX_BLOCKS - 1));
    issue(REQ_RELEASE, IDX_W'(MAX_BLOCKS - 1));
    issue(REQ_UNUSED, '1);
    issue(REQ_MARK, IDX_W'(4));
    issue(REQ_ALLOC, '0);
    issue(REQ_RELEASE, IDX_W'(1));
    issue(REQ_ALLOC, '1);
    drain();

    // Count of zero: nothing tracked at all.
    write_count('0);
    issue(REQ_ALLOC, '0);
    issue(REQ_RELEASE, IDX_W'(2));
    issue(REQ_MARK, IDX_W'(6));
    drain();

    // Tiny map: out-of-range mark, then a full map.
    write_count(CFG_W'(3));
    issue(REQ_MARK, IDX_W'(3));
    issue(REQ_ALLOC, '0);
    issue(REQ_RELEASE, IDX_W'(2));
    issue(REQ_ALLOC, '0);
    drain();

    // Count above capacity acts as full capacity.
    write_count('1);
    issue(REQ_MARK, '1);
    issue(REQ_ALLOC, '0);
    issue(REQ_RELEASE, IDX_W'(16'h4000));
    drain();

    // Random phases, each at its own block count; small counts fill up and
    // exercise none_free, large ones walk past words filled earlier.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: count = CFG_W'(1);
        1: count = CFG_W'(WORD_BITS);
        2: count = CFG_W'($urandom_range(2, WORD_BITS - 1));
        3: count = CFG_W'($urandom_range(WORD_BITS + 1, 200));
        4: count = CFG_W'(MAX_BLOCKS);
        5: count = '1;
        6: count = CFG_W'($urandom_range(MAX_BLOCKS + 1, 65535));
        7: count = CFG_W'($urandom_range(1, 16));
        8: count = CFG_W'($urandom_range(200, 2000));
        default: count = CFG_W'($urandom_range(1, 65535));
      endcase
      write_count(count);
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45)      issue(REQ_ALLOC, IDX_W'($urandom));
        else if (r < 75) issue(REQ_RELEASE, pick_index());
        else if (r < 92) issue(REQ_MARK, pick_index());
        else             issue(REQ_UNUSED, IDX_W'($urandom));
      end
      drain();
    end

    // Let a late stray result show up before judging.
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bitmap_block_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dpath.sv
hw/rtl/bitmap_block_allocator.sv
hw/rtl/bba_checker.sv
tb/sv/bba_grant_sb_pkg.sv
tb/sv/tb_top.sv
